// ----- design/ikstep_pkg.sv -----
// Shared types, constants and helper functions of the two-link inverse-kinematics step unit.
package ikstep_pkg;

  localparam int IDX_W  = 5;

  localparam logic signed [23:0] PI_Q16      = 24'sd205887;
  localparam logic signed [23:0] HALF_PI_Q16 = 24'sd102944;
  localparam logic signed [23:0] TURN_Q16    = 24'sd411775;
  localparam logic signed [23:0] TWO_TURN    = 24'sd823550;
  localparam longint CORDIC_GAIN_Q30 = 652032875;

  // Configuration register indexes.
  localparam logic [2:0] REG_UPPER_LEN = 3'd0;
  localparam logic [2:0] REG_LOWER_LEN = 3'd1;
  localparam logic [2:0] REG_GOAL_X    = 3'd2;
  localparam logic [2:0] REG_GOAL_Y    = 3'd3;
  localparam logic [2:0] REG_GAIN      = 3'd4;
  localparam logic [2:0] REG_START_ONE = 3'd5;
  localparam logic [2:0] REG_START_TWO = 3'd6;

  // Steps of the shared multiplier sequence.
  localparam logic [IDX_W-1:0] MS_XA    = 5'd0;
  localparam logic [IDX_W-1:0] MS_XB    = 5'd1;
  localparam logic [IDX_W-1:0] MS_YA    = 5'd2;
  localparam logic [IDX_W-1:0] MS_YB    = 5'd3;
  localparam logic [IDX_W-1:0] MS_TIP   = 5'd4;
  localparam logic [IDX_W-1:0] MS_ERR   = 5'd5;
  localparam logic [IDX_W-1:0] MS_DET0  = 5'd6;
  localparam logic [IDX_W-1:0] MS_DET1  = 5'd7;
  localparam logic [IDX_W-1:0] MS_N1A   = 5'd8;
  localparam logic [IDX_W-1:0] MS_N1B   = 5'd9;
  localparam logic [IDX_W-1:0] MS_N2A   = 5'd10;
  localparam logic [IDX_W-1:0] MS_N2B   = 5'd11;
  localparam logic [IDX_W-1:0] MS_GAIN1 = 5'd12;
  localparam logic [IDX_W-1:0] MS_GAIN2 = 5'd13;
  localparam logic [IDX_W-1:0] DIV_TOP  = 5'd19;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CINIT, OP_CITER, OP_CFIN, OP_MUL,
    OP_DINIT, OP_DITER, OP_DFIN, OP_WRAP, OP_PUB
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic singular;
  } status_t;

  function automatic longint arc_q30(input logic [IDX_W-1:0] i);
    case (i)
      5'd0:  return 843314857;
      5'd1:  return 497837830;
      5'd2:  return 263043837;
      5'd3:  return 133525159;
      5'd4:  return 67021687;
      5'd5:  return 33543515;
      5'd6:  return 16775851;
      5'd7:  return 8388437;
      5'd8:  return 4194283;
      5'd9:  return 2097149;
      5'd10: return 1048576;
      5'd11: return 524288;
      5'd12: return 262144;
      5'd13: return 131072;
      5'd14: return 65536;
      5'd15: return 32768;
      5'd16: return 16384;
      5'd17: return 8192;
      5'd18: return 4096;
      5'd19: return 2048;
      5'd20: return 1024;
      5'd21: return 512;
      5'd22: return 256;
      5'd23: return 128;
      default: return 0;
    endcase
  endfunction

  // Arctangent step rounded to the working fraction width.
  function automatic logic [31:0] arc_work(input logic [IDX_W-1:0] i, input int f);
    longint v;
    int sh;
    sh = 30 - f;
    v = (arc_q30(i) + (longint'(1) << (sh - 1))) >> sh;
    return v[31:0];
  endfunction

  // Maps an angle into one turn around zero; input lies within two and a half turns of zero.
  function automatic logic signed [18:0] wrap_angle(input logic signed [21:0] v);
    logic signed [23:0] m;
    m = 24'(v) + PI_Q16;
    if (m >= TWO_TURN)       m = m - TWO_TURN;
    else if (m >= TURN_Q16)  m = m - TURN_Q16;
    else if (m < -TURN_Q16)  m = m + TWO_TURN;
    else if (m < 24'sd0)     m = m + TURN_Q16;
    m = m - PI_Q16;
    return m[18:0];
  endfunction

endpackage

// ----- design/two_link_jacobian_ik_step_unit.sv -----
// Top level: one Jacobian inverse-kinematics step of a planar two-link arm per request.
// Each request runs through the serial CORDIC passes, the twelve shared-multiplier steps
// and the 20-step divider.
// A singular arm skips the divider, the gain steps and the angle update.
// Requests are taken one at a time; a new request stalls until the last result is published.
// Synchronous reset restores the register defaults and clears both joint angles.
module two_link_jacobian_ik_step_unit #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int FRAC_BITS         = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [18:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] angle_one,
  output logic signed [18:0] angle_two,
  output logic signed [19:0] delta_one,
  output logic signed [19:0] delta_two,
  output logic signed [18:0] error_x,
  output logic signed [18:0] error_y,
  output logic               singular
);
  import ikstep_pkg::*;

  cmd_t    cmd;
  status_t status;

  ikstep_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ikstep_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .restart   (restart),
    .cmd       (cmd),
    .status    (status),
    .angle_one (angle_one),
    .angle_two (angle_two),
    .delta_one (delta_one),
    .delta_two (delta_two),
    .error_x   (error_x),
    .error_y   (error_y),
    .singular  (singular)
  );

endmodule

// ----- design/ikstep_ctrl.sv -----
// Sequencer that steps the datapath through one inverse-kinematics iteration.
module ikstep_ctrl #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ikstep_pkg::status_t status,
  output ikstep_pkg::cmd_t    cmd
);
  import ikstep_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CINIT, S_CITER, S_CFIN, S_MUL, S_DINIT, S_DITER, S_DFIN,
    S_GAIN, S_WRAP, S_PUB
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;
  logic             phase;
  logic             can_pub;

  assign in_stall = (state != S_IDLE);
  assign can_pub  = !out_valid || !out_stall;

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.idx = cnt;
    case (state)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_CINIT: begin cmd.op = OP_CINIT; cmd.idx = {{(IDX_W-1){1'b0}}, phase}; end
      S_CITER: cmd.op = OP_CITER;
      S_CFIN:  begin cmd.op = OP_CFIN; cmd.idx = {{(IDX_W-1){1'b0}}, phase}; end
      S_MUL:   cmd.op = OP_MUL;
      S_DINIT: cmd.op = OP_DINIT;
      S_DITER: cmd.op = OP_DITER;
      S_DFIN:  cmd.op = OP_DFIN;
      S_GAIN:  cmd.op = OP_MUL;
      S_WRAP:  cmd.op = OP_WRAP;
      S_PUB:   cmd.op = can_pub ? OP_PUB : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PUB && can_pub) out_valid <= 1'b1;
      else if (!out_stall)           out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CINIT;
            phase <= 1'b0;
          end
        end
        S_CINIT: begin
          state <= S_CITER;
          cnt   <= '0;
        end
        S_CITER: begin
          if (cnt == IDX_W'(CORDIC_ITERATIONS - 1)) state <= S_CFIN;
          else cnt <= cnt + 1'b1;
        end
        S_CFIN: begin
          if (!phase) begin
            phase <= 1'b1;
            state <= S_CINIT;
          end else begin
            state <= S_MUL;
            cnt   <= MS_XA;
          end
        end
        S_MUL: begin
          // A zero determinant skips the solve and leaves the angles alone.
          if (cnt == MS_N2B) state <= status.singular ? S_PUB : S_DINIT;
          else cnt <= cnt + 1'b1;
        end
        S_DINIT: begin
          state <= S_DITER;
          cnt   <= DIV_TOP;
        end
        S_DITER: begin
          if (cnt == '0) state <= S_DFIN;
          else cnt <= cnt - 1'b1;
        end
        S_DFIN: begin
          state <= S_GAIN;
          cnt   <= MS_GAIN1;
        end
        S_GAIN: begin
          if (cnt == MS_GAIN2) state <= S_WRAP;
          else cnt <= cnt + 1'b1;
        end
        S_WRAP: state <= S_PUB;
        S_PUB: begin
          if (can_pub) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/ikstep_dp.sv -----
// Datapath: configuration, joint angles, CORDIC unit, shared multiplier and divider lanes.
module ikstep_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [18:0]         cfg_data,
  input  logic                restart,
  input  ikstep_pkg::cmd_t    cmd,
  output ikstep_pkg::status_t status,
  output logic signed [18:0]  angle_one,
  output logic signed [18:0]  angle_two,
  output logic signed [19:0]  delta_one,
  output logic signed [19:0]  delta_two,
  output logic signed [18:0]  error_x,
  output logic signed [18:0]  error_y,
  output logic                singular
);
  import ikstep_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int WW   = F + 3;
  localparam int UP   = (F >= 16) ? F - 16 : 0;
  localparam int DN   = (F >= 16) ? 0 : 16 - F;
  localparam int RDN  = (2 ** DN) / 2;
  localparam int SHO  = (F >= 16) ? F - 16 : 0;
  localparam int RSHO = (2 ** SHO) / 2;
  localparam int UPO  = (F >= 16) ? 0 : 16 - F;
  localparam int GSH  = 30 - F;
  localparam longint XINIT = (CORDIC_GAIN_Q30 + (longint'(1) << (GSH - 1))) >> GSH;

  // Configuration registers.
  logic [15:0]        l1, l2, gain;
  logic signed [17:0] gx, gy;
  logic signed [18:0] st1, st2;

  // Joint angles.
  logic signed [18:0] a1, a2;

  // CORDIC unit.
  logic signed [WW-1:0] x, y, z;
  logic                 flip;
  logic signed [17:0]   c1, s1, c12, s12;
  logic signed [18:0]   a_pick, a_fold;
  logic                 fold_flip;
  logic signed [39:0]   z_shift, z_round;
  logic signed [WW-1:0] dx, dy, da;
  logic signed [17:0]   c_fin, s_fin;

  // Products and sums.
  logic signed [17:0] pxa, pxb, pya, pyb;
  logic signed [18:0] xh, yh, ex, ey;
  logic signed [39:0] det, n1, n2;
  logic signed [19:0] ma, mb;
  logic signed [39:0] prod, rnd16;
  logic signed [21:0] t1, t2;

  // Divider lanes.
  logic [57:0]        dabs, rem1, rem2, sub;
  logic [19:0]        q1, q2;
  logic               ovf1, ovf2, neg1, neg2;
  logic signed [19:0] d1, d2;
  logic [57:0]        num1, num2;

  function automatic logic signed [17:0] to_q16(input logic signed [WW-1:0] v,
                                                input logic neg);
    logic signed [39:0] e;
    logic signed [17:0] r;
    e = 40'(v);
    e = ((e + 40'(RSHO)) >>> SHO) <<< UPO;
    if (e > 40'sd65536)       r = 18'sd65536;
    else if (e < -40'sd65536) r = -18'sd65536;
    else                      r = e[17:0];
    return neg ? -r : r;
  endfunction

  function automatic logic signed [19:0] div_result(input logic [19:0] q, input logic ovf,
                                                    input logic neg);
    logic signed [20:0] nq;
    nq = -$signed({1'b0, q});
    if (ovf)                 return neg ? -20'sd524288 : 20'sd524287;
    else if (!neg)           return q[19] ? 20'sd524287 : $signed(q);
    else if (q > 20'd524288) return -20'sd524288;
    else                     return nq[19:0];
  endfunction

  function automatic logic [57:0] mag(input logic signed [39:0] v);
    logic [39:0] m;
    m = v[39] ? 40'(-v) : 40'(v);
    return 58'(m);
  endfunction

  assign status.singular = (det == '0);

  always_comb begin
    a_pick = cmd.idx[0] ? wrap_angle(22'(a1) + 22'(a2)) : a1;
    a_fold = a_pick;
    fold_flip = 1'b0;
    if (24'(a_pick) > HALF_PI_Q16) begin
      a_fold = 19'(24'(a_pick) - PI_Q16);
      fold_flip = 1'b1;
    end else if (24'(a_pick) < -HALF_PI_Q16) begin
      a_fold = 19'(24'(a_pick) + PI_Q16);
      fold_flip = 1'b1;
    end
    z_shift = 40'(a_fold) <<< UP;
    z_round = (z_shift + 40'(RDN)) >>> DN;
    dx = y >>> cmd.idx;
    dy = x >>> cmd.idx;
    da = $signed(WW'(arc_work(cmd.idx, F)));
    c_fin = to_q16(x, flip);
    s_fin = to_q16(y, flip);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.idx)
      MS_XA:    begin ma = $signed({4'b0, l1}); mb = 20'(c1);   end
      MS_XB:    begin ma = $signed({4'b0, l2}); mb = 20'(c12);  end
      MS_YA:    begin ma = $signed({4'b0, l1}); mb = 20'(s1);   end
      MS_YB:    begin ma = $signed({4'b0, l2}); mb = 20'(s12);  end
      MS_DET0:  begin ma = -20'(yh);            mb = 20'(pxb);  end
      MS_DET1:  begin ma = -20'(pyb);           mb = 20'(xh);   end
      MS_N1A:   begin ma = 20'(pxb);            mb = 20'(ex);   end
      MS_N1B:   begin ma = -20'(pyb);           mb = 20'(ey);   end
      MS_N2A:   begin ma = -20'(yh);            mb = 20'(ey);   end
      MS_N2B:   begin ma = 20'(xh);             mb = 20'(ex);   end
      MS_GAIN1: begin ma = $signed({4'b0, gain}); mb = d1;      end
      MS_GAIN2: begin ma = $signed({4'b0, gain}); mb = d2;      end
      default:  begin ma = '0; mb = '0; end
    endcase
    prod  = 40'(ma) * 40'(mb);
    rnd16 = (prod + 40'sd32768) >>> 16;
    sub   = dabs << cmd.idx;
    num1  = mag(n1) << 16;
    num2  = mag(n2) << 16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l1   <= 16'd6554;
      l2   <= 16'd6554;
      gx   <= 18'sd6554;
      gy   <= 18'sd9830;
      gain <= 16'd655;
      st1  <= '0;
      st2  <= '0;
      a1   <= '0;
      a2   <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_UPPER_LEN: l1   <= cfg_data[15:0];
          REG_LOWER_LEN: l2   <= cfg_data[15:0];
          REG_GOAL_X:    gx   <= $signed(cfg_data[17:0]);
          REG_GOAL_Y:    gy   <= $signed(cfg_data[17:0]);
          REG_GAIN:      gain <= cfg_data[15:0];
          REG_START_ONE: st1  <= $signed(cfg_data);
          REG_START_TWO: st2  <= $signed(cfg_data);
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          if (restart) begin
            a1 <= wrap_angle(22'(st1));
            a2 <= wrap_angle(22'(st2));
          end
        end
        OP_WRAP: begin
          a1 <= wrap_angle(t1);
          a2 <= wrap_angle(t2);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CINIT: begin
        x    <= WW'(XINIT);
        y    <= '0;
        z    <= WW'(z_round);
        flip <= fold_flip;
      end
      OP_CITER: begin
        if (!z[WW-1]) begin
          x <= x - dx; y <= y + dy; z <= z - da;
        end else begin
          x <= x + dx; y <= y - dy; z <= z + da;
        end
      end
      OP_CFIN: begin
        if (cmd.idx[0]) begin c12 <= c_fin; s12 <= s_fin; end
        else            begin c1  <= c_fin; s1  <= s_fin; end
      end
      OP_MUL: begin
        case (cmd.idx)
          MS_XA:    pxa <= rnd16[17:0];
          MS_XB:    pxb <= rnd16[17:0];
          MS_YA:    pya <= rnd16[17:0];
          MS_YB:    pyb <= rnd16[17:0];
          MS_TIP: begin
            xh <= 19'(pxa) + 19'(pxb);
            yh <= 19'(pya) + 19'(pyb);
          end
          MS_ERR: begin
            ex <= 19'(gx) - xh;
            ey <= 19'(gy) - yh;
          end
          MS_DET0:  det <= prod;
          MS_DET1:  det <= det - prod;
          MS_N1A:   n1  <= prod;
          MS_N1B:   n1  <= n1 - prod;
          MS_N2A:   n2  <= prod;
          MS_N2B:   n2  <= n2 - prod;
          MS_GAIN1: t1  <= 22'(a1) + rnd16[21:0];
          MS_GAIN2: t2  <= 22'(a2) + rnd16[21:0];
          default: ;
        endcase
      end
      OP_DINIT: begin
        dabs <= mag(det);
        rem1 <= num1;
        rem2 <= num2;
        ovf1 <= num1 >= (mag(det) << 20);
        ovf2 <= num2 >= (mag(det) << 20);
        neg1 <= n1[39] ^ det[39];
        neg2 <= n2[39] ^ det[39];
        q1   <= '0;
        q2   <= '0;
      end
      OP_DITER: begin
        if (rem1 >= sub) begin rem1 <= rem1 - sub; q1 <= {q1[18:0], 1'b1}; end
        else             q1 <= {q1[18:0], 1'b0};
        if (rem2 >= sub) begin rem2 <= rem2 - sub; q2 <= {q2[18:0], 1'b1}; end
        else             q2 <= {q2[18:0], 1'b0};
      end
      OP_DFIN: begin
        d1 <= div_result(q1, ovf1, neg1);
        d2 <= div_result(q2, ovf2, neg2);
      end
      OP_PUB: begin
        angle_one <= a1;
        angle_two <= a2;
        delta_one <= status.singular ? '0 : d1;
        delta_two <= status.singular ? '0 : d2;
        error_x   <= ex;
        error_y   <= ey;
        singular  <= status.singular;
      end
      default: ;
    endcase
  end

endmodule

// ----- dv/two_link_jacobian_ik_step_unit_tb.sv -----
// Self-checking testbench for the two-link inverse-kinematics step unit.
`timescale 1ns / 1ps

module two_link_jacobian_ik_step_unit_tb;
  import ikstep_pkg::*;

  typedef struct packed {
    logic signed [18:0] angle_one;
    logic signed [18:0] angle_two;
    logic signed [19:0] delta_one;
    logic signed [19:0] delta_two;
    logic signed [18:0] error_x;
    logic signed [18:0] error_y;
    logic               singular;
  } ik_result_t;

  typedef struct packed {
    logic [6:0][18:0] regs;
    logic             restart;
    logic             typed;
    ik_result_t       want;
  } step_row_t;

  localparam longint ARC_Q30 [16] = '{843314857, 497837830, 263043837, 133525159,
    67021687, 33543515, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768};
  localparam int REG_W [7] = '{16, 16, 18, 18, 16, 19, 19};
  localparam int LIMIT = 3000000;

  logic clk, rst, cfg_write, in_valid, in_stall, restart, out_valid, out_stall;
  logic [2:0] cfg_index;
  logic [18:0] cfg_data;
  ik_result_t got;

  two_link_jacobian_ik_step_unit uut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
    .out_valid(out_valid), .out_stall(out_stall), .angle_one(got.angle_one),
    .angle_two(got.angle_two), .delta_one(got.delta_one), .delta_two(got.delta_two),
    .error_x(got.error_x), .error_y(got.error_y), .singular(got.singular)
  );

  // Shadow of the block: registers and joint angles.
  logic [18:0] arm_reg [7];
  longint      joint_one, joint_two;
  ik_result_t  pending_steps[$];
  int          mismatches, steps_sent, steps_checked, singular_seen, cycles;
  int          send_idle_pct, recv_idle_pct;
  step_row_t   rows [12];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic longint round_q16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint wrap_turn(input longint v);
    longint m;
    m = (v + 205887) % 411775;
    if (m < 0) m += 411775;
    return m - 205887;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void cordic_sin_cos(input longint a, output longint c, output longint s);
    longint x, y, z, dx, dy, da;
    bit flip;
    flip = 0;
    if (a > 102944) begin
      a -= 205887;
      flip = 1;
    end else if (a < -102944) begin
      a += 205887;
      flip = 1;
    end
    z = a;
    x = (652032875 + 8192) >>> 14;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      da = (ARC_Q30[i] + 8192) >>> 14;
      if (z >= 0) begin
        x -= dx; y += dy; z -= da;
      end else begin
        x += dx; y -= dy; z += da;
      end
    end
    x = clip(x, -65536, 65536);
    y = clip(y, -65536, 65536);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic ik_result_t solve_ik_step(input logic rs);
    longint l1, l2, gx, gy, gain, c1, s1, c12, s12, xh, yh, ex, ey;
    longint j00, j01, j10, j11, det, d1, d2;
    ik_result_t r;
    l1 = arm_reg[REG_UPPER_LEN][15:0];
    l2 = arm_reg[REG_LOWER_LEN][15:0];
    gx = $signed(arm_reg[REG_GOAL_X][17:0]);
    gy = $signed(arm_reg[REG_GOAL_Y][17:0]);
    gain = arm_reg[REG_GAIN][15:0];
    d1 = 0;
    d2 = 0;
    if (rs) begin
      joint_one = wrap_turn($signed(arm_reg[REG_START_ONE]));
      joint_two = wrap_turn($signed(arm_reg[REG_START_TWO]));
    end
    cordic_sin_cos(joint_one, c1, s1);
    cordic_sin_cos(wrap_turn(joint_one + joint_two), c12, s12);
    xh = round_q16(l1 * c1) + round_q16(l2 * c12);
    yh = round_q16(l1 * s1) + round_q16(l2 * s12);
    ex = gx - xh;
    ey = gy - yh;
    j00 = -yh;
    j01 = -round_q16(l2 * s12);
    j10 = xh;
    j11 = round_q16(l2 * c12);
    det = j00 * j11 - j01 * j10;
    if (det != 0) begin
      d1 = clip(((j11 * ex - j01 * ey) * 65536) / det, -524288, 524287);
      d2 = clip(((j00 * ey - j10 * ex) * 65536) / det, -524288, 524287);
      joint_one = wrap_turn(joint_one + round_q16(gain * d1));
      joint_two = wrap_turn(joint_two + round_q16(gain * d2));
    end
    r.angle_one = joint_one[18:0];
    r.angle_two = joint_two[18:0];
    r.delta_one = d1[19:0];
    r.delta_two = d2[19:0];
    r.error_x = ex[18:0];
    r.error_y = ey[18:0];
    r.singular = (det == 0);
    return r;
  endfunction

  function automatic step_row_t mk(input int l1, l2, gx, gy, g, s1, s2, input logic rs);
    step_row_t r;
    r = '0;
    r.regs[REG_UPPER_LEN] = 19'(l1);
    r.regs[REG_LOWER_LEN] = 19'(l2);
    r.regs[REG_GOAL_X] = 19'(gx);
    r.regs[REG_GOAL_Y] = 19'(gy);
    r.regs[REG_GAIN] = 19'(g);
    r.regs[REG_START_ONE] = 19'(s1);
    r.regs[REG_START_TWO] = 19'(s2);
    r.restart = rs;
    return r;
  endfunction

  // Receiver side: random stall and result checking.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (!rst && out_valid && !out_stall) begin
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        ik_result_t exp_r;
        exp_r = pending_steps.pop_front();
        steps_checked++;
        if (got.singular) singular_seen++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at step %0d\n  expected %p\n  actual   %p",
                     steps_checked, exp_r, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_steps.size());
      $display("two_link_jacobian_ik_step_unit verification failed");
      $finish;
    end
  end

  // The write enable drops for one cycle after each write.
  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    if (idx < 7) arm_reg[idx] = val & ((19'd1 << REG_W[idx]) - 1);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_request(input logic rs, input logic typed, input ik_result_t want);
    ik_result_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = solve_ik_step(rs);
    pending_steps.push_back(typed ? want : p);
    steps_sent++;
  endtask

  initial begin
    step_row_t row;
    ik_result_t none;
    int n;
    none = '0;
    rst <= 1; cfg_write <= 0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 0; restart <= 0; out_stall <= 0;
    mismatches = 0; steps_sent = 0; steps_checked = 0; singular_seen = 0; cycles = 0;
    send_idle_pct = 30; recv_idle_pct = 62;
    arm_reg[0] = 6554; arm_reg[1] = 6554; arm_reg[2] = 6554; arm_reg[3] = 9830;
    arm_reg[4] = 655;  arm_reg[5] = 0;    arm_reg[6] = 0;
    joint_one = 0; joint_two = 0;

    rows[0]  = mk(6554, 6554, 6554, 9830, 655, 0, 0, 0);
    rows[1]  = mk(6554, 6554, 6554, 9830, 655, 0, 0, 1);
    // Zero link lengths give a zero determinant: angles held, error equals the goal.
    rows[2]  = mk(0, 0, 131071, -131072, 655, 0, 0, 1);
    rows[2].typed = 1;
    rows[2].want = '{19'sd0, 19'sd0, 20'sd0, 20'sd0, 19'sd131071, -19'sd131072, 1'b1};
    rows[3]  = mk(0, 0, -131072, 131071, 655, 0, 0, 0);
    rows[3].typed = 1;
    rows[3].want = '{19'sd0, 19'sd0, 20'sd0, 20'sd0, -19'sd131072, 19'sd131071, 1'b1};
    rows[4]  = mk(65535, 65535, 131071, 131071, 65535, 205887, -205887, 1);
    rows[5]  = mk(65535, 65535, 131071, 131071, 65535, 205887, -205887, 0);
    rows[6]  = mk(65535, 0, -131072, 0, 65535, 0, 0, 1);
    // Start angles beyond one half turn are wrapped on load.
    rows[7]  = mk(6554, 6554, 0, 0, 65535, 262143, -262144, 1);
    // Folded arm: the second joint at a half turn.
    rows[8]  = mk(32768, 32768, 1000, 1000, 655, 0, 205887, 1);
    rows[9]  = mk(32768, 32768, 20000, 30000, 0, 102944, -102944, 1);
    rows[10] = mk(32768, 32768, 20000, 30000, 40000, 102944, -102944, 0);
    rows[11] = mk(32768, 16384, 20000, 30000, 40000, -205887, 205887, 1);

    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // An unmapped register index must be ignored.
    write_reg(3'd7, 19'h7FFFF);

    for (int k = 0; k < 12; k++) begin
      row = rows[k];
      for (int i = 0; i < 7; i++)
        if (row.regs[i] != arm_reg[i]) begin
          drain();
          write_reg(3'(i), row.regs[i]);
        end
      send_request(row.restart, row.typed, row.typed ? row.want : none);
    end

    for (int ph = 0; ph < 9; ph++) begin
      send_idle_pct = ph < 3 ? 30 : (ph < 6 ? 62 : 0);
      recv_idle_pct = ph < 3 ? 62 : (ph < 6 ? 30 : 0);
      drain();
      for (int i = 0; i < 7; i++) write_reg(3'(i), 19'($urandom));
      if (ph == 8) begin
        write_reg(REG_UPPER_LEN, 19'h7FFFF);
        write_reg(REG_GAIN, 19'h7FFFF);
      end else if ($urandom_range(2) == 0) begin
        // Reachable goals with moderate gain drive real convergence.
        write_reg(REG_UPPER_LEN, 19'($urandom_range(8000, 40000)));
        write_reg(REG_LOWER_LEN, 19'($urandom_range(8000, 40000)));
        write_reg(REG_GOAL_X, 19'($urandom_range(0, 40000) - 20000));
        write_reg(REG_GOAL_Y, 19'($urandom_range(0, 40000) - 20000));
        write_reg(REG_GAIN, 19'($urandom_range(0, 20000)));
      end
      n = 220;
      for (int j = 0; j < n; j++)
        send_request(j == 0 || $urandom_range(9) == 0, 1'b0, none);
    end

    drain();
    repeat (100) @(posedge clk);
    $display("ran %0d steps (%0d singular), %0d checked, %0d mismatches", steps_sent,
             singular_seen, steps_checked, mismatches);
    $display("covered register extremes, restart wrap, singular arms and three idle mixes");
    if (mismatches == 0 && pending_steps.size() == 0)
      $display("two_link_jacobian_ik_step_unit verification clean");
    else
      $display("two_link_jacobian_ik_step_unit verification failed");
    $finish;
  end

endmodule
